// ===== rtl/core/tts_pkg.sv =====
package tts_pkg;

    // Field and datapath widths
    localparam int TICK_W        = 64;
    localparam int US_W          = 64;
    localparam int COUNTER_W     = 16;
    localparam int FREQ_W        = 21;
    localparam int DIV_W         = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 21;
    localparam int QUOT_W        = 64;
    localparam int REM_W         = 21;
    localparam int STEP_W        = 5;
    localparam int BITS_PER_STEP = 4;
    localparam int MUL_A_W       = 32;
    localparam int MUL_B_W       = 20;
    localparam int MUL_P_W       = MUL_A_W + MUL_B_W;
    localparam int SECS_W        = 44;

    // Default depth of the sample queue between the front and back parts
    localparam int QUEUE_DEPTH = 2;

    // Timer constants
    localparam logic [FREQ_W-1:0]  BASE_HZ    = 21'd1193182;
    localparam logic [FREQ_W-1:0]  DEFAULT_HZ = 21'd100;
    localparam logic [DIV_W-1:0]   DIV_MAX    = 16'hFFFF;
    localparam logic [MUL_B_W-1:0] US_PER_S   = 20'd1000000;

    // Divider jobs: the dividend is left-aligned, four quotient bits per cycle
    localparam logic [STEP_W-1:0] DIVF_STEPS = 5'd6;    // 24-bit base clock
    localparam int                DIVF_SHIFT = 40;
    localparam logic [STEP_W-1:0] DIVC_STEPS = 5'd16;   // 64-bit cycle total
    localparam logic [STEP_W-1:0] DIVR_STEPS = 5'd11;   // 44-bit scaled remainder
    localparam int                DIVR_SHIFT = 20;

    // Item action codes
    localparam logic ACT_TICK   = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PROGRAMMED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQUENCY  = 2'd1;

    // A classified sample waiting for the back part
    typedef struct packed {
        logic [TICK_W-1:0]    tick_count;
        logic [COUNTER_W-1:0] counter;
    } sample_t;

    // Divider request and response
    typedef struct packed {
        logic              start;
        logic [QUOT_W-1:0] dividend;
        logic [REM_W-1:0]  divisor;
        logic [STEP_W-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quotient;
        logic [REM_W-1:0]  remainder;
    } div_rsp_t;

endpackage

// ===== rtl/core/tts_if.sv =====
// Input item channel
interface tts_item_if;
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic [tts_pkg::COUNTER_W-1:0] counter;

    modport source (output valid, action, counter, input ready);
    modport sink (input valid, action, counter, output ready);
endinterface

// Result channel
interface tts_result_if;
    logic                       valid;
    logic                       ready;
    logic [tts_pkg::TICK_W-1:0] tick_count;
    logic [tts_pkg::US_W-1:0]   microseconds;

    modport source (output valid, tick_count, microseconds, input ready);
    modport sink (input valid, tick_count, microseconds, output ready);
endinterface

// Configuration write channel
interface tts_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [tts_pkg::CFG_IDX_W-1:0]  index;
    logic [tts_pkg::CFG_DATA_W-1:0] wdata;

    modport source (output valid, index, wdata, input ready);
    modport sink (input valid, index, wdata, output ready);
endinterface

// ===== rtl/core/tts_front.sv =====
module tts_front (
    input  logic              clk,
    input  logic              rst_n,
    tts_item_if.sink          item,
    input  logic              full,
    output logic              push,
    output tts_pkg::sample_t  push_data
);

    logic [tts_pkg::TICK_W-1:0] ticks_reg;
    logic [tts_pkg::TICK_W-1:0] ticks_next;
    logic                       accept;

    // Items are taken whenever the queue has room
    assign item.ready = !full;
    assign accept     = item.valid && item.ready;

    // A tick bumps the count; a sample snapshots it together with the counter
    always_comb
    begin
        ticks_next = ticks_reg;
        push       = 1'b0;
        if (accept)
        begin
            if (item.action == tts_pkg::ACT_TICK)
            begin
                ticks_next = ticks_reg + 1'b1;
            end
            else
            begin
                push = 1'b1;
            end
        end
    end

    assign push_data.tick_count = ticks_reg;
    assign push_data.counter    = item.counter;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg <= '0;
        end
        else
        begin
            ticks_reg <= ticks_next;
        end
    end

endmodule

// ===== rtl/core/tts_queue.sv =====
module tts_queue #(
    parameter int DEPTH = tts_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  tts_pkg::sample_t push_data,
    output logic             full,
    input  logic             pop,
    output tts_pkg::sample_t pop_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tts_pkg::sample_t   entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |-> (count_reg < CNT_W'(DEPTH)))
        else $error("sample queue written while full");

endmodule

// ===== rtl/core/tts_divider.sv =====
module tts_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  tts_pkg::div_req_t req,
    output tts_pkg::div_rsp_t rsp
);

    logic                         busy_reg;
    logic                         busy_next;
    logic                         done_reg;
    logic                         done_next;
    logic [tts_pkg::STEP_W-1:0]   cnt_reg;
    logic [tts_pkg::STEP_W-1:0]   cnt_next;
    logic [tts_pkg::QUOT_W-1:0]   quo_reg;
    logic [tts_pkg::REM_W-1:0]    rem_reg;
    logic [tts_pkg::REM_W-1:0]    dsor_reg;
    logic [tts_pkg::QUOT_W-1:0]   quo_step;
    logic [tts_pkg::REM_W-1:0]    rem_step;
    logic [tts_pkg::REM_W:0]      trial;

    // Four restoring steps per cycle: shift in a dividend bit, try to subtract
    always_comb
    begin
        quo_step = quo_reg;
        rem_step = rem_reg;
        trial    = '0;
        for (int k = 0; k < tts_pkg::BITS_PER_STEP; k++)
        begin
            trial = {rem_step, quo_step[tts_pkg::QUOT_W-1]} - {1'b0, dsor_reg};
            if (!trial[tts_pkg::REM_W])
            begin
                rem_step = trial[tts_pkg::REM_W-1:0];
                quo_step = {quo_step[tts_pkg::QUOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_step = {rem_step[tts_pkg::REM_W-2:0], quo_step[tts_pkg::QUOT_W-1]};
                quo_step = {quo_step[tts_pkg::QUOT_W-2:0], 1'b0};
            end
        end
    end

    // Step counter; done pulses once after the last step
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = req.steps;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == tts_pkg::STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operand and partial result registers
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg  <= req.dividend;
            rem_reg  <= '0;
            dsor_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_step;
            rem_reg <= rem_step;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

    a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("divider started while busy");

endmodule

// ===== rtl/core/tts_back.sv =====
module tts_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          empty,
    input  tts_pkg::sample_t              head,
    output logic                          pop,
    input  logic                          programmed,
    input  logic [tts_pkg::FREQ_W-1:0]    tick_rate,
    tts_result_if.source                  result
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_F,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_ADD_C,
        ST_DIV_C,
        ST_MUL_SL,
        ST_MUL_SH,
        ST_MUL_R,
        ST_START_R,
        ST_DIV_R,
        ST_DONE
    } state_t;

    state_t                         state_reg;
    state_t                         state_next;
    logic                           res_valid_reg;
    logic                           res_valid_next;
    logic [tts_pkg::TICK_W-1:0]     res_tick_reg;
    logic [tts_pkg::US_W-1:0]       res_us_reg;
    logic                           res_load;

    logic [tts_pkg::TICK_W-1:0]     tick_reg;
    logic [tts_pkg::TICK_W-1:0]     tick_next;
    logic [tts_pkg::COUNTER_W-1:0]  cnt_in_reg;
    logic [tts_pkg::COUNTER_W-1:0]  cnt_in_next;
    logic [tts_pkg::DIV_W-1:0]      div_reg;
    logic [tts_pkg::DIV_W-1:0]      div_next;
    logic [tts_pkg::MUL_P_W-1:0]    prod_reg;
    logic [tts_pkg::MUL_P_W-1:0]    prod_next;
    logic [tts_pkg::US_W-1:0]       acc_reg;
    logic [tts_pkg::US_W-1:0]       acc_next;
    logic [tts_pkg::SECS_W-1:0]     secs_reg;
    logic [tts_pkg::SECS_W-1:0]     secs_next;
    logic [tts_pkg::REM_W-1:0]      frac_reg;
    logic [tts_pkg::REM_W-1:0]      frac_next;
    logic [tts_pkg::US_W-1:0]       us_reg;
    logic [tts_pkg::US_W-1:0]       us_next;

    logic [tts_pkg::MUL_A_W-1:0]    mul_a;
    logic [tts_pkg::MUL_B_W-1:0]    mul_b;
    logic [tts_pkg::FREQ_W-1:0]     freq_eff;
    logic [tts_pkg::DIV_W-1:0]      div_clamped;
    logic [tts_pkg::DIV_W-1:0]      elapsed;
    logic [tts_pkg::TICK_W-1:0]     cycles_sum;

    tts_pkg::div_req_t              div_req;
    tts_pkg::div_rsp_t              div_rsp;

    tts_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Operand preparation shared by the states below
    assign freq_eff   = (tick_rate == '0) ? tts_pkg::DEFAULT_HZ : tick_rate;
    assign elapsed    = (cnt_in_reg > div_reg) ? '0 : div_reg - cnt_in_reg;
    assign cycles_sum = acc_reg + {prod_reg[tts_pkg::MUL_A_W-1:0], 32'b0};

    // Clamp the reload divisor to 1..65535
    always_comb
    begin
        if (div_rsp.quotient == '0)
        begin
            div_clamped = tts_pkg::DIV_W'(1);
        end
        else if (div_rsp.quotient > tts_pkg::QUOT_W'(tts_pkg::DIV_MAX))
        begin
            div_clamped = tts_pkg::DIV_MAX;
        end
        else
        begin
            div_clamped = div_rsp.quotient[tts_pkg::DIV_W-1:0];
        end
    end

    // Output register is free when empty or being drained this cycle
    assign res_load = (state_reg == ST_DONE) && (!res_valid_reg || result.ready);

    // Sequencer: divisor, cycle total, seconds split, scaling
    always_comb
    begin
        state_next       = state_reg;
        pop              = 1'b0;
        tick_next        = tick_reg;
        cnt_in_next      = cnt_in_reg;
        div_next         = div_reg;
        acc_next         = acc_reg;
        secs_next        = secs_reg;
        frac_next        = frac_reg;
        us_next          = us_reg;
        mul_a            = '0;
        mul_b            = '0;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = tts_pkg::BASE_HZ;
        div_req.steps    = tts_pkg::DIVC_STEPS;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    pop         = 1'b1;
                    tick_next   = head.tick_count;
                    cnt_in_next = head.counter;
                    if (programmed)
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = tts_pkg::QUOT_W'(tts_pkg::BASE_HZ)
                                           << tts_pkg::DIVF_SHIFT;
                        div_req.divisor  = freq_eff;
                        div_req.steps    = tts_pkg::DIVF_STEPS;
                        state_next       = ST_DIV_F;
                    end
                    else
                    begin
                        us_next    = '0;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DIV_F:
            begin
                if (div_rsp.done)
                begin
                    div_next   = div_clamped;
                    state_next = ST_MUL_LO;
                end
            end
            ST_MUL_LO:
            begin
                mul_a      = tick_reg[31:0];
                mul_b      = tts_pkg::MUL_B_W'(div_reg);
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI:
            begin
                mul_a      = tick_reg[63:32];
                mul_b      = tts_pkg::MUL_B_W'(div_reg);
                acc_next   = tts_pkg::US_W'(prod_reg) + tts_pkg::US_W'(elapsed);
                state_next = ST_ADD_C;
            end
            ST_ADD_C:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = cycles_sum;
                div_req.divisor  = tts_pkg::BASE_HZ;
                div_req.steps    = tts_pkg::DIVC_STEPS;
                state_next       = ST_DIV_C;
            end
            ST_DIV_C:
            begin
                if (div_rsp.done)
                begin
                    secs_next  = div_rsp.quotient[tts_pkg::SECS_W-1:0];
                    frac_next  = div_rsp.remainder;
                    state_next = ST_MUL_SL;
                end
            end
            ST_MUL_SL:
            begin
                mul_a      = secs_reg[31:0];
                mul_b      = tts_pkg::US_PER_S;
                state_next = ST_MUL_SH;
            end
            ST_MUL_SH:
            begin
                mul_a      = tts_pkg::MUL_A_W'(secs_reg[tts_pkg::SECS_W-1:32]);
                mul_b      = tts_pkg::US_PER_S;
                acc_next   = tts_pkg::US_W'(prod_reg);
                state_next = ST_MUL_R;
            end
            ST_MUL_R:
            begin
                mul_a      = tts_pkg::MUL_A_W'(frac_reg);
                mul_b      = tts_pkg::US_PER_S;
                acc_next   = cycles_sum;
                state_next = ST_START_R;
            end
            ST_START_R:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = {prod_reg[43:0], 20'b0};
                div_req.divisor  = tts_pkg::BASE_HZ;
                div_req.steps    = tts_pkg::DIVR_STEPS;
                state_next       = ST_DIV_R;
            end
            ST_DIV_R:
            begin
                if (div_rsp.done)
                begin
                    us_next    = acc_reg + div_rsp.quotient;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (res_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Shared multiplier, registered
    assign prod_next = tts_pkg::MUL_P_W'(mul_a) * tts_pkg::MUL_P_W'(mul_b);

    // Result valid flag
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_valid_reg && result.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        tick_reg   <= tick_next;
        cnt_in_reg <= cnt_in_next;
        div_reg    <= div_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        secs_reg   <= secs_next;
        frac_reg   <= frac_next;
        us_reg     <= us_next;
        if (res_load)
        begin
            res_tick_reg <= tick_reg;
            res_us_reg   <= us_reg;
        end
    end

    assign result.valid        = res_valid_reg;
    assign result.tick_count   = res_tick_reg;
    assign result.microseconds = res_us_reg;

    a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_DIV_F || state_reg == ST_DIV_C ||
                          state_reg == ST_DIV_R))
        else $error("divider finished while the sequencer was not waiting");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result presented outside the completion state");

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (state_reg != ST_IDLE))
        else $error("sequencer stayed idle after taking a sample");

endmodule

// ===== rtl/core/tick_timestamp_microseconds_unit.sv =====
// Interrupt tick counter with microsecond timestamps. A tick transaction adds one to a
// 64-bit count and produces no result; the front part takes one tick per cycle while the
// sample queue is not full. A sample transaction carries the latched down-counter and
// returns the tick count and the time since start in microseconds (0 while not
// programmed). The back part handles one sample at a time; a programmed sample uses the
// shared iterative divider, which retires four quotient bits per cycle, over three
// divisions (reload divisor, whole seconds, fraction) plus five passes through the shared
// 32x20 multiplier; an unprogrammed sample skips the arithmetic. Samples wait in a short
// queue, so input is stalled only when that queue is full. Configuration writes are always
// accepted and must be issued while no sample is in flight.
module tick_timestamp_microseconds_unit #(
    parameter int QUEUE_DEPTH = tts_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    tts_item_if.sink      item,
    tts_result_if.source  result,
    tts_cfg_if.sink       cfg
);

    logic                          programmed_reg;
    logic                          programmed_next;
    logic [tts_pkg::FREQ_W-1:0]    frequency_reg;
    logic [tts_pkg::FREQ_W-1:0]    frequency_next;

    logic                          push;
    tts_pkg::sample_t              push_data;
    logic                          full;
    logic                          pop;
    tts_pkg::sample_t              head;
    logic                          empty;

    // Configuration registers; writes beyond the list are dropped
    assign cfg.ready = 1'b1;

    always_comb
    begin
        programmed_next = programmed_reg;
        frequency_next  = frequency_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                tts_pkg::CFG_PROGRAMMED:
                begin
                    programmed_next = cfg.wdata[0];
                end
                tts_pkg::CFG_FREQUENCY:
                begin
                    frequency_next = cfg.wdata[tts_pkg::FREQ_W-1:0];
                end
                default:
                begin
                    programmed_next = programmed_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            programmed_reg <= 1'b0;
            frequency_reg  <= '0;
        end
        else
        begin
            programmed_reg <= programmed_next;
            frequency_reg  <= frequency_next;
        end
    end

    // Front part: counts ticks and classifies samples
    tts_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .full      (full),
        .push      (push),
        .push_data (push_data)
    );

    // Sample queue
    tts_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (head),
        .empty     (empty)
    );

    // Back part: timestamp arithmetic and result register
    tts_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .empty        (empty),
        .head         (head),
        .pop          (pop),
        .programmed   (programmed_reg),
        .tick_rate    (frequency_reg),
        .result       (result)
    );

endmodule

// ===== test/tick_timestamp_microseconds_unit_checker.sv =====
// Watches the item, result and configuration channels, predicts the timestamp that
// each sample transaction should return, and compares every result against it.
module tick_timestamp_microseconds_unit_checker
    import tts_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    tts_item_if    item,
    tts_result_if  result,
    tts_cfg_if     cfg,
    output int     fail_count,
    output int     stamps_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [TICK_W-1:0] tick_count;
        logic [US_W-1:0]   microseconds;
    } timestamp_t;

    // Shadow copy of the block state and its registers.
    logic [TICK_W-1:0] tick_total;
    logic              armed;
    logic [FREQ_W-1:0] rate_hz;

    // Timestamps owed by the block, oldest first.
    timestamp_t stamps_due[$];

    // Reload divisor for a requested tick rate; zero selects the default rate.
    function automatic logic [DIV_W-1:0] reload_of(logic [FREQ_W-1:0] hz);
        logic [FREQ_W-1:0] rate;
        logic [FREQ_W-1:0] quotient;
        rate = (hz == '0) ? DEFAULT_HZ : hz;
        quotient = BASE_HZ / rate;
        if (quotient == '0)
        begin
            return 16'd1;
        end
        if (quotient > DIV_MAX)
        begin
            return DIV_MAX;
        end
        return quotient[DIV_W-1:0];
    endfunction

    // Base clock cycles to microseconds, truncating whole seconds and fraction apart.
    function automatic logic [US_W-1:0] micros_of(logic [63:0] cycles);
        logic [63:0] secs;
        logic [63:0] frac;
        secs = cycles / 64'(BASE_HZ);
        frac = cycles % 64'(BASE_HZ);
        return secs * 64'(US_PER_S) + (frac * 64'(US_PER_S)) / 64'(BASE_HZ);
    endfunction

    function automatic timestamp_t predict_stamp(logic [COUNTER_W-1:0] latched);
        timestamp_t       stamp;
        logic [DIV_W-1:0] reload;
        logic [63:0]      elapsed;
        stamp.tick_count = tick_total;
        stamp.microseconds = '0;
        if (armed)
        begin
            reload = reload_of(rate_hz);
            // A counter above the reload value counts as no elapsed cycles.
            elapsed = (latched > reload) ? 64'd0 : 64'(reload - latched);
            stamp.microseconds = micros_of(tick_total * 64'(reload) + elapsed);
        end
        return stamp;
    endfunction

    // Track every accepted transaction at the clock edge where it happens.
    always @(posedge clk or negedge rst_n)
    begin
        timestamp_t due;
        if (!rst_n)
        begin
            tick_total = '0;
            armed = 1'b0;
            rate_hz = '0;
            stamps_due.delete();
            fail_count = 0;
            stamps_pending = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_PROGRAMMED: armed = cfg.wdata[0];
                    CFG_FREQUENCY:  rate_hz = cfg.wdata[FREQ_W-1:0];
                    default: ;
                endcase
            end

            if (item.valid && item.ready)
            begin
                if (item.action == ACT_TICK)
                    tick_total = tick_total + 1'b1;
                else
                    stamps_due.push_back(predict_stamp(item.counter));
            end

            if (result.valid && result.ready)
            begin
                if (stamps_due.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result: expected none, got tick_count %0d us %0d",
                             $time, result.tick_count, result.microseconds);
                end
                else
                begin
                    due = stamps_due.pop_front();
                    if (result.tick_count !== due.tick_count)
                    begin
                        fail_count++;
                        $display("%0t: tick_count mismatch: expected %0d, got %0d",
                                 $time, due.tick_count, result.tick_count);
                    end
                    if (result.microseconds !== due.microseconds)
                    begin
                        fail_count++;
                        $display("%0t: microseconds mismatch: expected %0d, got %0d",
                                 $time, due.microseconds, result.microseconds);
                    end
                end
            end

            stamps_pending = stamps_due.size();
        end
    end

endmodule

// ===== test/tick_timestamp_microseconds_unit_tb.sv =====
// Drives tick and sample transactions and register writes into the timestamp unit;
// the checker beside it predicts and compares the results.
module tick_timestamp_microseconds_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tts_pkg::*;

    // Register indexes past the defined ones; writes there must have no effect.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    localparam int SETTLE_CYCLES  = 50;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEMS_PER_RUN  = 130;

    logic clk;
    logic rst_n;
    int   tx_idle_pct;
    int   rx_idle_pct;
    int   fail_count;
    int   stamps_pending;
    int   quiet_cycles;

    tts_item_if   item_ch ();
    tts_result_if result_ch ();
    tts_cfg_if    cfg_ch ();

    tick_timestamp_microseconds_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    tick_timestamp_microseconds_unit_checker checker_inst (
        .clk            (clk),
        .rst_n          (rst_n),
        .item           (item_ch),
        .result         (result_ch),
        .cfg            (cfg_ch),
        .fail_count     (fail_count),
        .stamps_pending (stamps_pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // Result side back-pressure, redrawn every cycle.
    initial
    begin
        result_ch.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            result_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // End the run if no transaction of any kind completes for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(logic act, logic [COUNTER_W-1:0] cnt);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.action <= act;
        item_ch.counter <= cnt;
        do
            @(posedge clk);
        while (!item_ch.ready);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.wdata <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    // Wait until every sample has returned, then let any trailing tick drain.
    task automatic settle();
        item_ch.valid <= 1'b0;
        while (stamps_pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Programmed flag write with random upper bits, which the register drops.
    function automatic logic [CFG_DATA_W-1:0] arm_word(logic on);
        logic [CFG_DATA_W-1:0] word;
        word = CFG_DATA_W'($urandom);
        word[0] = on;
        return word;
    endfunction

    // Counters cluster around the reload value, the field extremes, or are fully random.
    task automatic random_item(logic [COUNTER_W-1:0] pivot);
        logic                 act;
        logic [COUNTER_W-1:0] cnt;
        int                   pick;
        act = $urandom_range(1) ? ACT_SAMPLE : ACT_TICK;
        pick = $urandom_range(9);
        if (pick == 0)
            cnt = '0;
        else if (pick == 1)
            cnt = '1;
        else if (pick < 5)
            cnt = pivot + COUNTER_W'($urandom_range(2)) - 1'b1;
        else
            cnt = COUNTER_W'($urandom);
        send_item(act, cnt);
    endtask

    initial
    begin
        logic [FREQ_W-1:0]    run_hz;
        logic [COUNTER_W-1:0] pivot;
        logic                 run_armed;

        rst_n <= 1'b0;
        item_ch.valid <= 1'b0;
        item_ch.action <= ACT_TICK;
        item_ch.counter <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= CFG_PROGRAMMED;
        cfg_ch.wdata <= '0;
        tx_idle_pct = 36;
        rx_idle_pct = 52;
        quiet_cycles = 0;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Before programming: samples carry the tick count and zero microseconds.
        send_item(ACT_SAMPLE, 16'h0000);
        send_item(ACT_SAMPLE, 16'hFFFF);
        send_item(ACT_TICK, 16'h0000);
        send_item(ACT_TICK, 16'hFFFF);
        send_item(ACT_SAMPLE, 16'd1234);
        settle();

        // Default rate: reload 11931; counters at, just past and below it.
        write_reg(CFG_PROGRAMMED, arm_word(1'b1));
        write_reg(CFG_FREQUENCY, 21'd0);
        send_item(ACT_SAMPLE, 16'd0);
        send_item(ACT_SAMPLE, 16'd11931);
        send_item(ACT_SAMPLE, 16'd11932);
        send_item(ACT_SAMPLE, 16'hFFFF);
        send_item(ACT_TICK, 16'hFFFF);
        send_item(ACT_SAMPLE, 16'd11930);
        settle();

        // Rate equal to the base clock gives a reload of one.
        write_reg(CFG_FREQUENCY, BASE_HZ);
        send_item(ACT_SAMPLE, 16'd0);
        send_item(ACT_SAMPLE, 16'd1);
        send_item(ACT_SAMPLE, 16'd2);
        settle();

        // Rate above the base clock: the quotient is zero and clamps to one.
        write_reg(CFG_FREQUENCY, BASE_HZ + 1'b1);
        send_item(ACT_SAMPLE, 16'd0);
        settle();

        // Lowest rate: the reload clamps to its 16-bit maximum.
        write_reg(CFG_FREQUENCY, 21'd1);
        send_item(ACT_SAMPLE, 16'd0);
        send_item(ACT_SAMPLE, 16'hFFFF);
        send_item(ACT_SAMPLE, 16'hFFFE);
        settle();

        // Writes to spare indexes change nothing.
        write_reg(CFG_SPARE_LO, '0);
        write_reg(CFG_SPARE_HI, '1);
        send_item(ACT_SAMPLE, 16'd100);
        settle();

        // Upper bits set but bit zero clear leaves the timer unprogrammed.
        write_reg(CFG_PROGRAMMED, 21'h1FFFFE);
        send_item(ACT_SAMPLE, 16'd0);
        settle();

        // Random runs, each under its own rate; each pair of runs shares an idling pattern.
        for (int run = 0; run < 6; run++)
        begin
            case (run / 2)
                0:
                begin
                    tx_idle_pct = 36;
                    rx_idle_pct = 52;
                end
                1:
                begin
                    tx_idle_pct = 52;
                    rx_idle_pct = 36;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase

            run_armed = 1'b1;
            case (run)
                0:
                begin
                    run_hz = 21'd0;
                    pivot = 16'd11931;
                end
                1:
                begin
                    run_hz = BASE_HZ;
                    pivot = 16'd1;
                end
                2:
                begin
                    run_hz = 21'd1;
                    pivot = 16'hFFFF;
                end
                3:
                begin
                    run_hz = 21'h1FFFFF;
                    pivot = 16'd1;
                    run_armed = 1'b0;
                end
                4:
                begin
                    run_hz = 21'd19;
                    pivot = 16'd62799;
                end
                default:
                begin
                    run_hz = FREQ_W'($urandom_range(200000, 20));
                    pivot = COUNTER_W'(BASE_HZ / run_hz);
                end
            endcase

            write_reg(CFG_SPARE_LO + CFG_IDX_W'($urandom_range(1)), CFG_DATA_W'($urandom));
            write_reg(CFG_FREQUENCY, run_hz);
            write_reg(CFG_PROGRAMMED, arm_word(run_armed));
            repeat (ITEMS_PER_RUN) random_item(pivot);
            settle();
        end

        if (fail_count == 0 && stamps_pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== tick_timestamp_microseconds_unit.f =====
rtl/core/tts_pkg.sv
rtl/core/tts_if.sv
rtl/core/tts_front.sv
rtl/core/tts_queue.sv
rtl/core/tts_divider.sv
rtl/core/tts_back.sv
rtl/core/tick_timestamp_microseconds_unit.sv
test/tick_timestamp_microseconds_unit_checker.sv
test/tick_timestamp_microseconds_unit_tb.sv
